// File: rtl/core/stgi_pkg.sv
package stgi_pkg;

  localparam int unsigned NUM_COEF   = 6;
  localparam int unsigned CW         = 32;   // coefficient, Q8.24
  localparam int unsigned MAGW       = 34;   // |e|
  localparam int unsigned SQW        = 68;   // e*e
  localparam int unsigned XW         = 37;   // x, Q5.32
  localparam int unsigned NW         = 6;    // exponent shift
  localparam int unsigned RW         = 32;   // reduced argument
  localparam int unsigned TW         = 33;   // series term
  localparam int unsigned SW         = 35;   // signed series sum
  localparam int unsigned VW         = 33;   // exp(-x), Q.32
  localparam int unsigned YW         = 37;   // x*exp(-x)
  localparam int unsigned DVW        = 53;   // derivative term
  localparam int unsigned TRMW       = 54;   // signed term
  localparam int unsigned ACCW       = 59;   // term sum
  localparam int unsigned OW         = 48;   // Q15.32 result
  localparam int unsigned NUM_K      = 12;   // series order
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  // floor(2^56 / LN2_Q32): estimate of x / ln2 from x[36:16]
  localparam logic [24:0] NEST_RECIP = 25'd24204406;

  // ceil(2^36 / k) for k = 1..12, exact floor division of 32-bit values
  localparam logic [36:0] DIV_RECIP [NUM_K] = '{
    37'd68719476736, 37'd34359738368, 37'd22906492246, 37'd17179869184,
    37'd13743895348, 37'd11453246123, 37'd9817068106,  37'd8589934592,
    37'd7635497416,  37'd6871947674,  37'd6247225158,  37'd5726623062
  };

  localparam logic CFG_INV_EPS_SQ   = 1'b0;
  localparam logic CFG_TWO_OVER_EPS = 1'b1;

  typedef logic signed [CW-1:0] coef_t;

  typedef struct packed {
    logic op;
    logic neg;
    logic zero;
    logic first;
    logic last;
  } term_ctl_t;

endpackage

// File: rtl/core/stgi_seq.sv
module stgi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [191:0]        in_tdata,
  input  logic [6:0]          in_tuser,
  input  logic                out_pop,
  output logic                term_v,
  output stgi_pkg::coef_t     term_c [stgi_pkg::NUM_COEF],
  output logic [4:0]          term_sgn,
  output stgi_pkg::term_ctl_t term_ctl
);

  logic            busy_r, busy_nxt;
  logic [4:0]      idx_r, idx_nxt;
  logic [2:0]      credit_r, credit_nxt;
  stgi_pkg::coef_t c_r [stgi_pkg::NUM_COEF];
  stgi_pkg::coef_t srt [stgi_pkg::NUM_COEF];
  logic [2:0]      sines_r;
  logic            op_r;
  logic            accept;
  logic [2:0]      pos [stgi_pkg::NUM_COEF];
  logic [2:0]      nc, ns, ncos;
  logic [5:0]      mask;
  logic            i_b, j_b, k_b, l_b, m_b;

  assign mask      = in_tuser[6:1];
  assign in_tready = (!busy_r || idx_r == 5'd31) &&
                     (credit_r != 3'(stgi_pkg::FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // stable reorder, cosine factors first
  always_comb begin
    nc   = 3'd0;
    ns   = 3'd0;
    ncos = 3'd6 - 3'($countones(mask));
    for (int n = 0; n < stgi_pkg::NUM_COEF; n++) begin
      if (!mask[n]) begin
        pos[n] = nc;
        nc     = nc + 3'd1;
      end else begin
        pos[n] = ncos + ns;
        ns     = ns + 3'd1;
      end
    end
    for (int p = 0; p < stgi_pkg::NUM_COEF; p++) begin
      srt[p] = '0;
      for (int n = 0; n < stgi_pkg::NUM_COEF; n++) begin
        if (pos[n] == 3'(p)) srt[p] = in_tdata[32*n +: 32];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (busy_r) begin
      idx_nxt = idx_r + 5'd1;
      if (idx_r == 5'd31) busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      idx_nxt  = 5'd0;
    end
    credit_nxt = credit_r + 3'(accept) - 3'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= 5'd0;
      credit_r <= 3'd0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_r     <= srt;
      sines_r <= ns;
      op_r    <= in_tuser[0];
    end
  end

  assign i_b = idx_r[4];
  assign j_b = idx_r[3];
  assign k_b = idx_r[2];
  assign l_b = idx_r[1];
  assign m_b = idx_r[0];

  assign term_v   = busy_r;
  assign term_c   = c_r;
  assign term_sgn = {l_b ^ k_b ^ m_b, l_b ^ m_b, j_b ^ m_b, m_b, i_b};

  always_comb begin
    term_ctl.op    = op_r;
    term_ctl.zero  = sines_r[0];
    term_ctl.first = (idx_r == 5'd0);
    term_ctl.last  = (idx_r == 5'd31);
    case (sines_r)
      3'd2:    term_ctl.neg = ~k_b;
      3'd4:    term_ctl.neg = j_b ^ k_b;
      3'd6:    term_ctl.neg = ~(i_b ^ j_b ^ k_b);
      default: term_ctl.neg = 1'b0;
    endcase
  end

endmodule

// File: rtl/core/stgi_arg.sv
module stgi_arg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       term_v,
  input  stgi_pkg::coef_t            term_c [stgi_pkg::NUM_COEF],
  input  logic [4:0]                 term_sgn,
  input  stgi_pkg::term_ctl_t        term_ctl,
  input  logic [31:0]                inv_eps_sq,
  output logic                       arg_v,
  output logic [stgi_pkg::XW-1:0]    arg_x,
  output logic [stgi_pkg::NW-1:0]    arg_n,
  output logic [stgi_pkg::RW-1:0]    arg_r,
  output stgi_pkg::term_ctl_t        arg_ctl
);

  logic signed [34:0]               e;
  logic [stgi_pkg::MAGW-1:0]        a1_mag_r;
  logic [stgi_pkg::SQW-1:0]         a2_sq_r;
  logic [65:0]                      a3_lo_r, a3_hi_r;
  logic [99:0]                      prod;
  logic [stgi_pkg::XW-1:0]          a4_x_r, a5_x_r, a6_x_r, a7_x_r;
  logic [45:0]                      nprod;
  logic [stgi_pkg::NW-1:0]          a5_n_r, a6_n_r, a7_n_r;
  logic [37:0]                      r0;
  logic [32:0]                      a6_r0_r;
  logic [stgi_pkg::RW-1:0]          a7_r_r;
  logic                             ge;
  logic [7:1]                       v_r;
  stgi_pkg::term_ctl_t              ctl_r [7:1];
  stgi_pkg::term_ctl_t              a4_ctl;

  always_comb begin
    e = 35'(term_c[0]);
    for (int p = 1; p < stgi_pkg::NUM_COEF; p++) begin
      e = term_sgn[p-1] ? e - 35'(term_c[p]) : e + 35'(term_c[p]);
    end
  end

  assign prod  = {a3_hi_r, 34'b0} + 100'(a3_lo_r);
  assign nprod = 46'(a4_x_r[36:16]) * 46'(stgi_pkg::NEST_RECIP);
  assign r0    = 38'(a5_x_r) - 38'(a5_n_r) * 38'(stgi_pkg::LN2_Q32);
  assign ge    = a6_r0_r >= 33'(stgi_pkg::LN2_Q32);

  always_comb begin
    a4_ctl      = ctl_r[3];
    a4_ctl.zero = ctl_r[3].zero || (|prod[99:69]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:1], term_v};
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[1] <= term_ctl;
    ctl_r[2] <= ctl_r[1];
    ctl_r[3] <= ctl_r[2];
    ctl_r[4] <= a4_ctl;
    ctl_r[5] <= ctl_r[4];
    ctl_r[6] <= ctl_r[5];
    ctl_r[7] <= ctl_r[6];

    a1_mag_r <= e[34] ? 34'(-e) : 34'(e);
    a2_sq_r  <= 68'(a1_mag_r) * 68'(a1_mag_r);
    a3_lo_r  <= 66'(a2_sq_r[33:0]) * 66'(inv_eps_sq);
    a3_hi_r  <= 66'(a2_sq_r[67:34]) * 66'(inv_eps_sq);
    a4_x_r   <= prod[68:32];
    a5_x_r   <= a4_x_r;
    a5_n_r   <= nprod[45:40];
    a6_x_r   <= a5_x_r;
    a6_n_r   <= a5_n_r;
    a6_r0_r  <= r0[32:0];
    a7_x_r   <= a6_x_r;
    // estimate may sit one below the true quotient
    a7_n_r   <= ge ? a6_n_r + 6'd1 : a6_n_r;
    a7_r_r   <= ge ? 32'(a6_r0_r - 33'(stgi_pkg::LN2_Q32)) : a6_r0_r[31:0];
  end

  assign arg_v   = v_r[7];
  assign arg_x   = a7_x_r;
  assign arg_n   = a7_n_r;
  assign arg_r   = a7_r_r;
  assign arg_ctl = ctl_r[7];

endmodule

// File: rtl/core/stgi_exp.sv
module stgi_exp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       arg_v,
  input  logic [stgi_pkg::XW-1:0]    arg_x,
  input  logic [stgi_pkg::NW-1:0]    arg_n,
  input  logic [stgi_pkg::RW-1:0]    arg_r,
  input  stgi_pkg::term_ctl_t        arg_ctl,
  output logic                       exp_v,
  output logic [stgi_pkg::VW-1:0]    exp_val,
  output logic [stgi_pkg::XW-1:0]    exp_x,
  output stgi_pkg::term_ctl_t        exp_ctl
);

  localparam int unsigned NST = 2 * stgi_pkg::NUM_K;

  logic                          st_v   [NST+1];
  logic [stgi_pkg::XW-1:0]       st_x   [NST+1];
  logic [stgi_pkg::NW-1:0]       st_n   [NST+1];
  logic [stgi_pkg::RW-1:0]       st_r   [NST+1];
  logic [stgi_pkg::TW-1:0]       st_t   [NST+1];
  logic signed [stgi_pkg::SW-1:0] st_sum [NST+1];
  stgi_pkg::term_ctl_t           st_ctl [NST+1];

  logic                          sh_v_r;
  logic [stgi_pkg::VW-1:0]       sh_val_r;
  logic [stgi_pkg::XW-1:0]       sh_x_r;
  stgi_pkg::term_ctl_t           sh_ctl_r;
  logic [32:0]                   sclip;

  assign st_v[0]   = arg_v;
  assign st_x[0]   = arg_x;
  assign st_n[0]   = arg_n;
  assign st_r[0]   = arg_r;
  assign st_t[0]   = 33'h1_0000_0000;
  assign st_sum[0] = 35'sh1_0000_0000;
  assign st_ctl[0] = arg_ctl;

  // each series term: multiply by r, then divide by k
  for (genvar g = 1; g <= NST; g++) begin : g_st
    localparam int unsigned K = (g + 1) / 2;
    logic [64:0]                    pm;
    logic [68:0]                    pd;
    logic [stgi_pkg::TW-1:0]        t_nxt;
    logic signed [stgi_pkg::SW-1:0] sum_nxt;

    always_comb begin
      pm      = 65'(st_t[g-1]) * 65'(st_r[g-1]);
      pd      = 69'(st_t[g-1][31:0]) * 69'(stgi_pkg::DIV_RECIP[K-1]);
      t_nxt   = st_t[g-1];
      sum_nxt = st_sum[g-1];
      if (g % 2 == 1) begin
        t_nxt = {1'b0, pm[63:32]};
      end else begin
        t_nxt = {1'b0, pd[67:36]};
        if (K % 2 == 1) sum_nxt = st_sum[g-1] - $signed({2'b0, t_nxt});
        else            sum_nxt = st_sum[g-1] + $signed({2'b0, t_nxt});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) st_v[g] <= 1'b0;
      else        st_v[g] <= st_v[g-1];
    end

    always_ff @(posedge clk) begin
      st_x[g]   <= st_x[g-1];
      st_n[g]   <= st_n[g-1];
      st_r[g]   <= st_r[g-1];
      st_ctl[g] <= st_ctl[g-1];
      st_t[g]   <= t_nxt;
      st_sum[g] <= sum_nxt;
    end
  end

  assign sclip = st_sum[NST][stgi_pkg::SW-1] ? 33'd0 : st_sum[NST][32:0];

  always_ff @(posedge clk) begin
    if (!rst_n) sh_v_r <= 1'b0;
    else        sh_v_r <= st_v[NST];
  end

  always_ff @(posedge clk) begin
    sh_val_r <= sclip >> st_n[NST];
    sh_x_r   <= st_x[NST];
    sh_ctl_r <= st_ctl[NST];
  end

  assign exp_v   = sh_v_r;
  assign exp_val = sh_val_r;
  assign exp_x   = sh_x_r;
  assign exp_ctl = sh_ctl_r;

endmodule

// File: rtl/core/stgi_acc.sv
module stgi_acc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       exp_v,
  input  logic [stgi_pkg::VW-1:0]    exp_val,
  input  logic [stgi_pkg::XW-1:0]    exp_x,
  input  stgi_pkg::term_ctl_t        exp_ctl,
  input  logic [31:0]                two_over_eps,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [stgi_pkg::OW-1:0]    out_tdata,
  output logic                       out_pop
);

  localparam int unsigned PW = $clog2(stgi_pkg::FIFO_DEPTH);

  logic [69:0]                        py;
  logic [68:0]                        pz;
  logic                               b1_v_r, b2_v_r, b3_v_r, fin_v_r;
  logic [stgi_pkg::YW-1:0]            b1_y_r;
  logic [stgi_pkg::VW-1:0]            b1_val_r;
  stgi_pkg::term_ctl_t                b1_ctl_r, b2_ctl_r, b3_ctl_r;
  logic [stgi_pkg::DVW-1:0]           mag, b2_mag_r;
  logic signed [stgi_pkg::TRMW-1:0]   b3_term_r;
  logic signed [stgi_pkg::ACCW-1:0]   acc_r, acc_nxt, fin_sum_r;
  logic signed [stgi_pkg::ACCW-1:0]   rnd;
  logic signed [53:0]                 q;
  logic [stgi_pkg::OW-1:0]            qsat;
  logic [stgi_pkg::OW-1:0]            mem_r [stgi_pkg::FIFO_DEPTH];
  logic [PW-1:0]                      wr_r, rd_r;
  logic [PW:0]                        cnt_r, cnt_nxt;

  assign py = 70'(exp_x) * 70'(exp_val);
  assign pz = 69'(b1_y_r) * 69'(two_over_eps);

  always_comb begin
    mag = b1_ctl_r.op ? pz[68:16] : 53'(b1_val_r);
    if (b1_ctl_r.zero) mag = '0;
  end

  assign acc_nxt = b3_ctl_r.first ? 59'(b3_term_r) : acc_r + 59'(b3_term_r);

  // divide by 32 toward zero, then clamp to Q15.32
  assign rnd = fin_sum_r + (fin_sum_r[stgi_pkg::ACCW-1] ? 59'sd31 : 59'sd0);
  assign q   = 54'(rnd >>> 5);
  always_comb begin
    if (q > 54'sh7FFF_FFFF_FFFF)       qsat = 48'h7FFF_FFFF_FFFF;
    else if (q < -54'sh8000_0000_0000) qsat = 48'h8000_0000_0000;
    else                               qsat = q[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else begin
      b1_v_r  <= exp_v;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      fin_v_r <= b3_v_r && b3_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    b1_y_r    <= py[68:32];
    b1_val_r  <= exp_val;
    b1_ctl_r  <= exp_ctl;
    b2_mag_r  <= mag;
    b2_ctl_r  <= b1_ctl_r;
    b3_term_r <= b2_ctl_r.neg ? -$signed({1'b0, b2_mag_r}) : $signed({1'b0, b2_mag_r});
    b3_ctl_r  <= b2_ctl_r;
    if (b3_v_r) acc_r <= acc_nxt;
    fin_sum_r <= acc_nxt;
  end

  // result queue, room is reserved by the issue credits
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = mem_r[rd_r];
  assign out_pop    = out_tvalid && out_tready;
  assign cnt_nxt    = cnt_r + (PW+1)'(fin_v_r) - (PW+1)'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fin_v_r) wr_r <= wr_r + PW'(1);
      if (out_pop) rd_r <= rd_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_v_r) mem_r[wr_r] <= qsat;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |-> (cnt_r != (PW+1)'(stgi_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(stgi_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_fin_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |-> $past(b3_v_r && b3_ctl_r.last))
    else $error("result without a closing term");

endmodule

// File: rtl/core/six_trig_product_gaussian_integral_top.sv
// a new input beat can be accepted while the previous item issues its last term
// throughput: one term a cycle through the shared exp pipeline (7 argument
// stages, series stages and a shift stage, sum stages)
// results wait in a 4-deep queue; input stalls while four items are in flight or queued
// rst_n is synchronous, active low: clears valids, counters and the queue,
// and restores inv_eps_sq to 1.0 and two_over_eps to 2.0
module six_trig_product_gaussian_integral_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // coef_0 .. coef_5
  input  logic [6:0]   in_tuser,   // op, sine_mask
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // integral_value
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0]                inv_eps_sq_r, two_over_eps_r;
  logic                       out_pop;
  logic                       term_v, arg_v, exp_v;
  stgi_pkg::coef_t            term_c [stgi_pkg::NUM_COEF];
  logic [4:0]                 term_sgn;
  stgi_pkg::term_ctl_t        term_ctl, arg_ctl, exp_ctl;
  logic [stgi_pkg::XW-1:0]    arg_x, exp_x;
  logic [stgi_pkg::NW-1:0]    arg_n;
  logic [stgi_pkg::RW-1:0]    arg_r;
  logic [stgi_pkg::VW-1:0]    exp_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_eps_sq_r   <= 32'd65536;
      two_over_eps_r <= 32'd131072;
    end else if (cfg_we) begin
      case (cfg_addr)
        stgi_pkg::CFG_INV_EPS_SQ:   inv_eps_sq_r   <= cfg_wdata;
        stgi_pkg::CFG_TWO_OVER_EPS: two_over_eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  stgi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_pop   (out_pop),
    .term_v    (term_v),
    .term_c    (term_c),
    .term_sgn  (term_sgn),
    .term_ctl  (term_ctl)
  );

  stgi_arg u_arg (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_v     (term_v),
    .term_c     (term_c),
    .term_sgn   (term_sgn),
    .term_ctl   (term_ctl),
    .inv_eps_sq (inv_eps_sq_r),
    .arg_v      (arg_v),
    .arg_x      (arg_x),
    .arg_n      (arg_n),
    .arg_r      (arg_r),
    .arg_ctl    (arg_ctl)
  );

  stgi_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .arg_v   (arg_v),
    .arg_x   (arg_x),
    .arg_n   (arg_n),
    .arg_r   (arg_r),
    .arg_ctl (arg_ctl),
    .exp_v   (exp_v),
    .exp_val (exp_val),
    .exp_x   (exp_x),
    .exp_ctl (exp_ctl)
  );

  stgi_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .exp_v        (exp_v),
    .exp_val      (exp_val),
    .exp_x        (exp_x),
    .exp_ctl      (exp_ctl),
    .two_over_eps (two_over_eps_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_pop      (out_pop)
  );

endmodule
